/* rtl/gha_pkg.sv */
// shared types and constants of the generational handle allocator
package gha_pkg;

  localparam int DEF_SLOTS = 1024;
  localparam int IN_IDX_W  = 10;
  localparam int LIVE_W    = 11;
  localparam int DOC_W     = 32;
  localparam int GEN_W     = 32;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_CHECK = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SLOT,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [1:0]          kind;
    logic [DOC_W-1:0]    handle_document;
    logic [IN_IDX_W-1:0] handle_index;
    logic [GEN_W-1:0]    handle_generation;
  } req_t;

  typedef struct packed {
    logic                ok;
    logic [DOC_W-1:0]    out_document;
    logic [IN_IDX_W-1:0] out_index;
    logic [GEN_W-1:0]    out_generation;
    logic [LIVE_W-1:0]   live_count;
  } res_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic slot_rd;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic pop;
  } sts_t;

endpackage

/* rtl/gha_ctrl.sv */
// controller state machine sequencing fetch, slot read and execute
module gha_ctrl
  import gha_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_FETCH;
        end
      end
      ST_FETCH: begin
        busy_o      = 1'b1;
        cmd_o.fetch = 1'b1;
        state_d     = sts_i.pop ? ST_SLOT : ST_EXEC;
      end
      ST_SLOT: begin
        busy_o        = 1'b1;
        cmd_o.slot_rd = 1'b1;
        state_d       = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_FETCH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/gha_datapath.sv */
// slot and free stack memories, counters and result register
module gha_datapath
  import gha_pkg::*;
#(
  parameter int SLOTS = DEF_SLOTS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  req_t             req_i,
  input  logic             cfg_valid_i,
  input  logic [DOC_W-1:0] cfg_data_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic             done_o,
  output res_t             res_o
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;
  localparam int MEM_W = GEN_W + 1;

  logic [MEM_W-1:0] slot_mem [SLOTS];
  logic [IDX_W-1:0] stack_mem [SLOTS];

  req_t             req_q;
  logic [DOC_W-1:0] doc_id_q;
  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] depth_q, depth_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic [MEM_W-1:0] slot_rd_q;
  logic [IDX_W-1:0] stack_q;
  logic             done_q;
  res_t             res_q, res_d;

  logic [IDX_W-1:0] slot_addr;
  logic [CNT_W-1:0] depth_m1;
  logic [IDX_W-1:0] stack_raddr;
  logic [IDX_W-1:0] idx_ext;
  logic             rd_alive;
  logic [GEN_W-1:0] rd_gen;
  logic             doc_nz;
  logic             handle_ok;
  logic             have_pop;
  logic             have_new;
  logic [IDX_W-1:0] alloc_slot;
  logic [GEN_W-1:0] alloc_gen;
  logic [GEN_W-1:0] gen_inc;
  logic             slot_we;
  logic [IDX_W-1:0] slot_waddr;
  logic [MEM_W-1:0] slot_wdata;
  logic             stack_we;

  assign idx_ext     = IDX_W'(req_q.handle_index);
  assign depth_m1    = depth_q - CNT_W'(1);
  assign stack_raddr = depth_m1[IDX_W-1:0];
  assign rd_alive    = slot_rd_q[MEM_W-1];
  assign rd_gen      = slot_rd_q[GEN_W-1:0];
  assign doc_nz      = (doc_id_q != '0);
  assign have_pop    = (depth_q != '0);
  assign have_new    = (used_q < CNT_W'(SLOTS));
  assign gen_inc     = rd_gen + GEN_W'(1);

  assign sts_o.pop = (req_q.kind == KIND_ALLOC) && doc_nz && have_pop;

  always_comb begin
    if (cmd_i.slot_rd) begin
      slot_addr = stack_q;
    end else if (req_q.kind == KIND_ALLOC) begin
      slot_addr = used_q[IDX_W-1:0];
    end else begin
      slot_addr = idx_ext;
    end
  end

  assign handle_ok = doc_nz && (req_q.handle_document == doc_id_q) &&
                     (CMP_W'(req_q.handle_index) < CMP_W'(used_q)) &&
                     rd_alive && (rd_gen == req_q.handle_generation);

  always_comb begin
    used_d     = used_q;
    depth_d    = depth_q;
    total_d    = total_q;
    slot_we    = 1'b0;
    slot_waddr = idx_ext;
    slot_wdata = '0;
    stack_we   = 1'b0;
    alloc_slot = have_pop ? stack_q : used_q[IDX_W-1:0];
    alloc_gen  = have_pop ? rd_gen : '0;
    res_d      = '0;
    case (req_q.kind)
      KIND_ALLOC: begin
        if (doc_nz && (have_pop || have_new)) begin
          slot_we    = 1'b1;
          slot_waddr = alloc_slot;
          slot_wdata = {1'b1, alloc_gen};
          total_d    = total_q + CNT_W'(1);
          if (have_pop) begin
            depth_d = depth_m1;
          end else begin
            used_d = used_q + CNT_W'(1);
          end
          res_d.ok             = 1'b1;
          res_d.out_document   = doc_id_q;
          res_d.out_index      = IN_IDX_W'(alloc_slot);
          res_d.out_generation = alloc_gen;
        end
      end
      KIND_FREE: begin
        if (handle_ok && (depth_q < CNT_W'(SLOTS))) begin
          slot_we    = 1'b1;
          slot_wdata = {1'b0, (gen_inc == '0) ? GEN_W'(1) : gen_inc};
          stack_we   = 1'b1;
          depth_d    = depth_q + CNT_W'(1);
          if (total_q != '0) begin
            total_d = total_q - CNT_W'(1);
          end
          res_d.ok = 1'b1;
        end
      end
      KIND_CHECK: begin
        res_d.ok = handle_ok;
      end
      default: begin
        res_d.ok = 1'b0;
      end
    endcase
    res_d.live_count = LIVE_W'(total_d);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (cmd_i.exec && stack_we) begin
      stack_mem[depth_q[IDX_W-1:0]] <= idx_ext;
    end
    if (cmd_i.fetch || cmd_i.slot_rd) begin
      slot_rd_q <= slot_mem[slot_addr];
    end
    if (cmd_i.fetch) begin
      stack_q <= stack_mem[stack_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      doc_id_q <= '0;
      used_q   <= '0;
      depth_q  <= '0;
      total_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        doc_id_q <= cfg_data_i;
      end
      if (cmd_i.exec) begin
        used_q  <= used_d;
        depth_q <= depth_d;
        total_q <= total_d;
      end
      done_q <= cmd_i.exec;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  // every used slot is either alive or parked on the free stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CNT_W + 1)'(total_q) + (CNT_W + 1)'(depth_q)) == (CNT_W + 1)'(used_q))
    else $error("live plus free count differs from used slots");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(SLOTS))
    else $error("used slot count beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.slot_rd |-> (depth_q != '0))
    else $error("stack pop with empty free stack");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && stack_we) |-> (slot_wdata[GEN_W-1:0] != '0))
    else $error("freed slot got generation zero");
`endif

endmodule

/* rtl/generational_handle_allocator_unit.sv */
// generational handle allocator top level
// a result strobes after the fetch and execute states that follow a start;
// an allocate reusing a slot from the free stack adds a slot read state between
// them (extra stack read before slot memory read), and execute accepts a new start
// reset: counters and document id clear at once, memories are not cleared
// (entries past the used-slot count read as fresh), no clearing pass
module generational_handle_allocator_unit
  import gha_pkg::*;
#(
  parameter int SLOTS = DEF_SLOTS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  output logic             done_o,
  output res_t             res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [DOC_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  gha_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  gha_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .res_o       (res_o)
  );

endmodule
